[rtl/http_chunked_body_decoder_macros.svh]
// Assertion macros for the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcbd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcbd: next-cycle check failed");

`endif

[rtl/hcbd_pkg.sv]
// Types, codes and a helper function for the chunked body decoder.
package hcbd_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_phase;

    // Result kinds.
    localparam t_kind KIND_FRAME   = 3'd0;
    localparam t_kind KIND_PAYLOAD = 3'd1;
    localparam t_kind KIND_DONE    = 3'd2;
    localparam t_kind KIND_ERROR   = 3'd3;
    localparam t_kind KIND_EXTRA   = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // Case-insensitive hex digit decode.
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            h.value = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/http_chunked_body_decoder.sv]
// Chunked HTTP/1.1 body decoder: one encoded byte in, one classified result out.
//
// Input channel: i_valid / o_stall carry i_data_byte, one byte of the
// chunk-encoded body per transfer. Output channel: o_valid / i_stall carry
// o_out_byte, o_kind and o_body_length, exactly one result per input byte.
// Kinds: framing byte, payload byte, body complete, error, byte after end.
//
// The result is registered: a byte accepted at a clock edge has its result in
// the output register after that edge. Throughput is one byte per clock while
// the receiver does not stall; the size-line parser and counters update
// combinationally from the stored parser state, the only loop in the design.
// When the receiver stalls, the result register holds and o_stall rises
// only while a held result is still waiting, so an item is taken in the
// same cycle the previous result is transferred.
// Synchronous active-low reset returns the parser to the start of a size
// line, clears the counters and empties the output register.
// Errors are sticky until reset; bytes after a completed body report extra.
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_kind,
    output logic [31:0] o_body_length
);

    localparam hcbd_pkg::t_phase PH_SIZE  = 3'd0;
    localparam hcbd_pkg::t_phase PH_DATA  = 3'd1;
    localparam hcbd_pkg::t_phase PH_TRAIL = 3'd2;
    localparam hcbd_pkg::t_phase PH_FINAL = 3'd3;
    localparam hcbd_pkg::t_phase PH_DONE  = 3'd4;
    localparam hcbd_pkg::t_phase PH_ERROR = 3'd5;

    hcbd_pkg::t_phase r_phase, n_phase;
    logic [30:0]      r_size_acc, n_size_acc;
    logic             r_seen_digit, n_seen_digit;
    logic             r_seen_cr, n_seen_cr;
    logic [30:0]      r_remaining, n_remaining;
    logic [31:0]      r_total, n_total;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    hcbd_pkg::t_kind  r_out_kind;
    logic [31:0]      r_out_length;

    hcbd_pkg::t_kind  w_kind;
    logic [7:0]       w_byte;
    logic [30:0]      w_rem_dec;
    hcbd_pkg::t_hex   w_hex;
    logic             w_in_fire;

    assign o_stall   = r_out_valid & i_stall;
    assign w_in_fire = i_valid & ~o_stall;
    assign w_hex     = hcbd_pkg::hex_decode(i_data_byte);
    assign w_rem_dec = (r_remaining != 31'd0) ? r_remaining - 31'd1 : 31'd0;

    always_comb begin
        n_phase      = r_phase;
        n_size_acc   = r_size_acc;
        n_seen_digit = r_seen_digit;
        n_seen_cr    = r_seen_cr;
        n_remaining  = r_remaining;
        n_total      = r_total;
        w_kind       = hcbd_pkg::KIND_FRAME;
        w_byte       = 8'd0;
        case (r_phase)
            PH_SIZE: begin
                if (r_seen_cr) begin
                    if (i_data_byte != hcbd_pkg::CHAR_LF) begin
                        n_phase = PH_ERROR;
                        w_kind  = hcbd_pkg::KIND_ERROR;
                    end else begin
                        n_seen_cr = 1'b0;
                        if (r_size_acc == 31'd0) begin
                            n_phase = PH_FINAL;
                        end else begin
                            n_remaining = r_size_acc;
                            n_phase     = PH_DATA;
                        end
                    end
                end else if (i_data_byte == hcbd_pkg::CHAR_CR) begin
                    if (!r_seen_digit) begin
                        n_phase = PH_ERROR;
                        w_kind  = hcbd_pkg::KIND_ERROR;
                    end else begin
                        n_seen_cr = 1'b1;
                    end
                end else if (!w_hex.ok || (r_size_acc[30:27] != 4'd0)) begin
                    // Another digit once bits 30:27 are set would push the size past 31 bits.
                    n_phase = PH_ERROR;
                    w_kind  = hcbd_pkg::KIND_ERROR;
                end else begin
                    n_size_acc   = {r_size_acc[26:0], w_hex.value};
                    n_seen_digit = 1'b1;
                end
            end
            PH_DATA: begin
                w_kind      = hcbd_pkg::KIND_PAYLOAD;
                w_byte      = i_data_byte;
                n_remaining = w_rem_dec;
                if (r_total != 32'hFFFF_FFFF) begin
                    n_total = r_total + 32'd1;
                end
                if (w_rem_dec == 31'd0) begin
                    n_phase   = PH_TRAIL;
                    n_seen_cr = 1'b0;
                end
            end
            PH_TRAIL: begin
                // The two bytes after a chunk's payload are skipped unchecked.
                if (r_seen_cr) begin
                    n_phase      = PH_SIZE;
                    n_size_acc   = 31'd0;
                    n_seen_digit = 1'b0;
                    n_seen_cr    = 1'b0;
                end else begin
                    n_seen_cr = 1'b1;
                end
            end
            PH_FINAL: begin
                if (!r_seen_cr) begin
                    if (i_data_byte == hcbd_pkg::CHAR_CR) begin
                        n_seen_cr = 1'b1;
                    end else begin
                        n_phase = PH_ERROR;
                        w_kind  = hcbd_pkg::KIND_ERROR;
                    end
                end else begin
                    n_seen_cr = 1'b0;
                    if (i_data_byte == hcbd_pkg::CHAR_LF) begin
                        n_phase = PH_DONE;
                        w_kind  = hcbd_pkg::KIND_DONE;
                    end else begin
                        n_phase = PH_ERROR;
                        w_kind  = hcbd_pkg::KIND_ERROR;
                    end
                end
            end
            PH_DONE: begin
                w_kind = hcbd_pkg::KIND_EXTRA;
            end
            default: begin
                n_phase = PH_ERROR;
                w_kind  = hcbd_pkg::KIND_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_size_acc   <= 31'd0;
            r_seen_digit <= 1'b0;
            r_seen_cr    <= 1'b0;
            r_remaining  <= 31'd0;
            r_total      <= 32'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_phase      <= n_phase;
                r_size_acc   <= n_size_acc;
                r_seen_digit <= n_seen_digit;
                r_seen_cr    <= n_seen_cr;
                r_remaining  <= n_remaining;
                r_total      <= n_total;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_byte   <= w_byte;
            r_out_kind   <= w_kind;
            r_out_length <= n_total;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_kind        = r_out_kind;
    assign o_body_length = r_out_length;

    `HCBD_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n, r_phase == PH_ERROR, r_phase == PH_ERROR)
    `HCBD_ASSERT_NEXT(a_done_sticky, i_clk, i_rst_n, r_phase == PH_DONE, r_phase == PH_DONE)
    `HCBD_ASSERT_IMPL(a_done_phase, i_clk, i_rst_n,
        o_valid && (o_kind == hcbd_pkg::KIND_DONE), r_phase == PH_DONE)
    `HCBD_ASSERT_IMPL(a_byte_zero, i_clk, i_rst_n,
        o_valid && (o_kind != hcbd_pkg::KIND_PAYLOAD), o_out_byte == 8'd0)

endmodule
